FILE: rtl/cte_pkg.sv
// ============================================================================
// cte_pkg
// Shared types, codes and the code length decoder of the trace event decoder.
// ============================================================================
package cte_pkg;

    // Event kinds as they leave the block.
    typedef enum logic [2:0] {
        EV_WRITE = 3'd0,
        EV_READ  = 3'd1,
        EV_INSTR = 3'd2,
        EV_REG   = 3'd3,
        EV_LINE  = 3'd4,
        EV_ERROR = 3'd5
    } kind_t;

    // Work orders passed from the front to the back through the queue.
    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_SEQ_READ = 3'd2,
        OP_INSTR    = 3'd3,
        OP_PC_SEQ   = 3'd4,
        OP_REG      = 3'd5,
        OP_LINE     = 3'd6,
        OP_ERROR    = 3'd7
    } op_t;

    // Register identifiers.
    localparam logic [3:0] REG_PC = 4'd0;
    localparam logic [3:0] REG_A  = 4'd1;
    localparam logic [3:0] REG_B  = 4'd2;
    localparam logic [3:0] REG_X  = 4'd3;
    localparam logic [3:0] REG_Y  = 4'd4;
    localparam logic [3:0] REG_CC = 4'd5;
    localparam logic [3:0] REG_U  = 4'd6;
    localparam logic [3:0] REG_S  = 4'd7;
    localparam logic [3:0] REG_DP = 4'd8;

    // Cycle count offsets of the short and long instruction forms.
    localparam logic [5:0] SHORT_CYCLE_BASE = 6'd2;
    localparam logic [5:0] LONG_CYCLE_BASE  = 6'd6;

    // Bit buffer size and byte width.
    localparam int BUF_W  = 40;
    localparam int BYTE_W = 8;

    // One queued code: its operation and the raw payload already extracted.
    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [15:0] data;
        logic [3:0]  reg_id;
        logic [1:0]  line_id;
        logic        line_level;
        logic [5:0]  cycles;
        logic        last;
    } entry_t;

    // Length of the code at the head of the buffer, or zero while it is
    // not complete. Bit 10 of h is the oldest pending bit, c the number of
    // pending bits.
    function automatic logic [4:0] code_len(input logic [10:0] h, input logic [5:0] c);
        logic [4:0] n;
        begin
            n = 5'd0;
            if (c >= 6'd3) begin
                if (h[10]) begin
                    if (h[9]) begin
                        if (h[8]) n = (c >= 6'd28) ? 5'd28 : 5'd0;
                        else      n = (c >= 6'd11) ? 5'd11 : 5'd0;
                    end else begin
                        if (h[8]) n = (c >= 6'd8) ? 5'd8 : 5'd0;
                        else      n = (c >= 6'd5) ? 5'd5 : 5'd0;
                    end
                end else if (!h[9]) begin
                    if (!h[8]) n = 5'd3;
                    else       n = (c >= 6'd19) ? 5'd19 : 5'd0;
                end else if (!h[8]) begin
                    n = (c >= 6'd12) ? 5'd12 : 5'd0;
                end else if (c >= 6'd5) begin
                    unique case (h[7:6]) inside
                        2'b00, 2'b01: n = (c >= 6'd21) ? 5'd21 : 5'd0;
                        2'b10:        n = (c >= 6'd13) ? 5'd13 : 5'd0;
                        default:
                        begin
                            if (c >= 6'd7) begin
                                unique case (h[5:4]) inside
                                    2'b00, 2'b01: n = (c >= 6'd23) ? 5'd23 : 5'd0;
                                    2'b10:        n = (c >= 6'd15) ? 5'd15 : 5'd0;
                                    default:
                                    begin
                                        if (c >= 6'd8) begin
                                            if (!h[3]) begin
                                                n = 5'd8;
                                            end else if (c >= 6'd10) begin
                                                if (h[2:1] == 2'b11) n = 5'd10;
                                                else if (c >= 6'd11) n = 5'd11;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            return n;
        end
    endfunction

endpackage

FILE: rtl/cte_front.sv
// ============================================================================
// cte_front
// Takes trace bytes into the bit buffer and splits off one code per cycle while the queue is not full.
// ============================================================================
module cte_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        stream_byte,
    output logic              push,
    output cte_pkg::entry_t   push_entry,
    input  logic              queue_full
);

    typedef enum logic [2:0] {
        FS_IDLE   = 3'b001,
        FS_DECODE = 3'b010,
        FS_HALT   = 3'b100
    } fstate_t;

    fstate_t                        state_reg, state_next;
    logic [cte_pkg::BUF_W-1:0]      buf_reg, buf_next;
    logic [5:0]                     cnt_reg, cnt_next;

    logic [4:0]                     len0;
    logic [4:0]                     len1;
    logic [5:0]                     cnt_rest;
    logic [cte_pkg::BUF_W-1:0]      shifted;
    logic [cte_pkg::BUF_W-1:0]      byte_placed;
    cte_pkg::entry_t                ent;

    // Length of the head code and of the code that follows it.
    assign len0     = cte_pkg::code_len(buf_reg[39:29], cnt_reg);
    assign shifted  = buf_reg << len0;
    assign cnt_rest = cnt_reg - {1'b0, len0};
    assign len1     = cte_pkg::code_len(shifted[39:29], cnt_rest);

    // New byte lands right behind the pending bits.
    assign byte_placed = {stream_byte, {(cte_pkg::BUF_W - cte_pkg::BYTE_W){1'b0}}} >> cnt_reg;

    // Classify the head code and pull out its payload.
    always_comb
    begin
        ent            = '0;
        ent.op         = cte_pkg::OP_ERROR;
        if (buf_reg[39]) begin
            if (buf_reg[38]) begin
                if (buf_reg[37]) begin
                    ent.op   = buf_reg[36] ? cte_pkg::OP_WRITE : cte_pkg::OP_READ;
                    ent.addr = buf_reg[35:20];
                    ent.data = {8'd0, buf_reg[19:12]};
                end else begin
                    ent.op   = cte_pkg::OP_SEQ_READ;
                    ent.data = {8'd0, buf_reg[36:29]};
                end
            end else begin
                ent.op = cte_pkg::OP_INSTR;
                if (buf_reg[37]) ent.cycles = {1'b0, buf_reg[36:32]} + cte_pkg::LONG_CYCLE_BASE;
                else             ent.cycles = {4'd0, buf_reg[36:35]} + cte_pkg::SHORT_CYCLE_BASE;
            end
        end else if (!buf_reg[38]) begin
            ent.reg_id = cte_pkg::REG_PC;
            if (!buf_reg[37]) begin
                ent.op = cte_pkg::OP_PC_SEQ;
            end else begin
                ent.op   = cte_pkg::OP_REG;
                ent.data = buf_reg[36:21];
            end
        end else if (!buf_reg[37]) begin
            ent.op     = cte_pkg::OP_REG;
            ent.reg_id = buf_reg[36] ? cte_pkg::REG_B : cte_pkg::REG_A;
            ent.data   = {8'd0, buf_reg[35:28]};
        end else begin
            ent.op = cte_pkg::OP_REG;
            unique case (buf_reg[36:35])
                2'b00:
                begin
                    ent.reg_id = cte_pkg::REG_X;
                    ent.data   = buf_reg[34:19];
                end
                2'b01:
                begin
                    ent.reg_id = cte_pkg::REG_Y;
                    ent.data   = buf_reg[34:19];
                end
                2'b10:
                begin
                    ent.reg_id = cte_pkg::REG_CC;
                    ent.data   = {8'd0, buf_reg[34:27]};
                end
                default:
                begin
                    unique case (buf_reg[34:33])
                        2'b00:
                        begin
                            ent.reg_id = cte_pkg::REG_U;
                            ent.data   = buf_reg[32:17];
                        end
                        2'b01:
                        begin
                            ent.reg_id = cte_pkg::REG_S;
                            ent.data   = buf_reg[32:17];
                        end
                        2'b10:
                        begin
                            ent.reg_id = cte_pkg::REG_DP;
                            ent.data   = {8'd0, buf_reg[32:25]};
                        end
                        default:
                        begin
                            if (!buf_reg[32] || (buf_reg[31:30] == 2'b11)) begin
                                ent.op = cte_pkg::OP_ERROR;
                            end else begin
                                ent.op         = cte_pkg::OP_LINE;
                                ent.line_id    = buf_reg[31:30];
                                ent.line_level = buf_reg[29];
                            end
                        end
                    endcase
                end
            endcase
        end
        ent.last = (ent.op == cte_pkg::OP_ERROR) || (len1 == 5'd0);
    end

    // While halted, bytes are still taken and simply dropped.
    assign in_ready   = (state_reg == FS_IDLE) || (state_reg == FS_HALT);
    assign push_entry = ent;

    // Control: take a byte, then peel codes until the buffer runs dry or a reserved code halts.
    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (in_valid) begin
                    buf_next   = buf_reg | byte_placed;
                    cnt_next   = cnt_reg + 6'd8;
                    state_next = FS_DECODE;
                end
            end
            FS_DECODE:
            begin
                if (len0 == 5'd0) begin
                    state_next = FS_IDLE;
                end else if (!queue_full) begin
                    push     = 1'b1;
                    buf_next = shifted;
                    cnt_next = cnt_rest;
                    if (ent.op == cte_pkg::OP_ERROR) begin
                        buf_next   = '0;
                        cnt_next   = '0;
                        state_next = FS_HALT;
                    end else if (ent.last) begin
                        state_next = FS_IDLE;
                    end
                end
            end
            FS_HALT:
            begin
                state_next = FS_HALT;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= FS_IDLE;
            buf_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/cte_queue.sv
// ============================================================================
// cte_queue
// Small first-in first-out queue of decoded codes between front and back.
// ============================================================================
module cte_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cte_pkg::entry_t   push_entry,
    output logic              full,
    input  logic              pop,
    output cte_pkg::entry_t   pop_entry,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cte_pkg::entry_t  entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)      cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: rtl/cte_back.sv
// ============================================================================
// cte_back
// Executes queued codes: tracks read address and instruction count, and
// holds the outgoing event beat.
// ============================================================================
module cte_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  cte_pkg::entry_t   pop_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        event_kind,
    output logic [15:0]       address,
    output logic [15:0]       data_value,
    output logic [3:0]        reg_id,
    output logic [1:0]        line_id,
    output logic              line_level,
    output logic [5:0]        cycle_count,
    output logic [31:0]       instr_index,
    output logic              last_in_run
);

    logic               valid_reg, valid_next;
    logic [15:0]        lra_reg, lra_next;
    logic [31:0]        icnt_reg, icnt_next;
    logic [15:0]        lra_inc;

    cte_pkg::kind_t     kind_reg, kind_next;
    logic [15:0]        addr_reg, addr_next;
    logic [15:0]        data_reg, data_next;
    logic [3:0]         regid_reg, regid_next;
    logic [1:0]         line_reg, line_next;
    logic               level_reg, level_next;
    logic [5:0]         cyc_reg, cyc_next;
    logic [31:0]        idx_reg, idx_next;
    logic               last_reg, last_next;

    assign pop     = !empty && (!valid_reg || out_ready);
    assign lra_inc = lra_reg + 16'd1;

    // Turn one queued code into an event and update the running state.
    always_comb
    begin
        valid_next = valid_reg;
        lra_next   = lra_reg;
        icnt_next  = icnt_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        regid_next = regid_reg;
        line_next  = line_reg;
        level_next = level_reg;
        cyc_next   = cyc_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        if (out_ready) valid_next = 1'b0;
        if (pop) begin
            valid_next = 1'b1;
            addr_next  = pop_entry.addr;
            data_next  = pop_entry.data;
            regid_next = pop_entry.reg_id;
            line_next  = pop_entry.line_id;
            level_next = pop_entry.line_level;
            cyc_next   = pop_entry.cycles;
            idx_next   = '0;
            last_next  = pop_entry.last;
            unique case (pop_entry.op)
                cte_pkg::OP_WRITE:
                begin
                    kind_next = cte_pkg::EV_WRITE;
                end
                cte_pkg::OP_READ:
                begin
                    kind_next = cte_pkg::EV_READ;
                    lra_next  = pop_entry.addr;
                end
                cte_pkg::OP_SEQ_READ:
                begin
                    kind_next = cte_pkg::EV_READ;
                    addr_next = lra_inc;
                    lra_next  = lra_inc;
                end
                cte_pkg::OP_INSTR:
                begin
                    kind_next = cte_pkg::EV_INSTR;
                    idx_next  = icnt_reg;
                    icnt_next = icnt_reg + 32'd1;
                end
                cte_pkg::OP_PC_SEQ:
                begin
                    kind_next = cte_pkg::EV_REG;
                    data_next = lra_inc;
                end
                cte_pkg::OP_REG:
                begin
                    kind_next = cte_pkg::EV_REG;
                end
                cte_pkg::OP_LINE:
                begin
                    kind_next = cte_pkg::EV_LINE;
                end
                default:
                begin
                    kind_next = cte_pkg::EV_ERROR;
                end
            endcase
        end
    end

    // Control and running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            lra_reg   <= '0;
            icnt_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            lra_reg   <= lra_next;
            icnt_reg  <= icnt_next;
        end
    end

    // Output beat payload.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        regid_reg <= regid_next;
        line_reg  <= line_next;
        level_reg <= level_next;
        cyc_reg   <= cyc_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
    end

    assign out_valid   = valid_reg;
    assign event_kind  = kind_reg;
    assign address     = addr_reg;
    assign data_value  = data_reg;
    assign reg_id      = regid_reg;
    assign line_id     = line_reg;
    assign line_level  = level_reg;
    assign cycle_count = cyc_reg;
    assign instr_index = idx_reg;
    assign last_in_run = last_reg;

endmodule

FILE: rtl/cpu_trace_event_decoder.sv
// ============================================================================
// cpu_trace_event_decoder
// Decodes a packed CPU trace, one byte per input beat, into event beats.
// ============================================================================
// Intake: a byte is loaded into the front, which splits every completed code
//   from it into the queue before it takes the next byte; a full queue stalls it.
// Path: a taken byte goes into the bit buffer, the front decodes its codes into
//   the queue, and the back moves each one into the output register.
// Reset: asynchronous; clears the bit buffer, read address, instruction
//   counter, queue and the halt (bytes taken and dropped) after a reserved code.
module cpu_trace_event_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [15:0] address,
    output logic [15:0] data_value,
    output logic [3:0]  reg_id,
    output logic [1:0]  line_id,
    output logic        line_level,
    output logic [5:0]  cycle_count,
    output logic [31:0] instr_index,
    output logic        last_in_run
);

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    cte_pkg::entry_t  push_entry;
    cte_pkg::entry_t  pop_entry;

    // Front: byte intake and code splitting.
    cte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .stream_byte(stream_byte),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (full)
    );

    // Queue between the two halves.
    cte_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .full      (full),
        .pop       (pop),
        .pop_entry (pop_entry),
        .empty     (empty)
    );

    // Back: event execution and output beat.
    cte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .address    (address),
        .data_value (data_value),
        .reg_id     (reg_id),
        .line_id    (line_id),
        .line_level (line_level),
        .cycle_count(cycle_count),
        .instr_index(instr_index),
        .last_in_run(last_in_run)
    );

endmodule

FILE: rtl/cte_checker.sv
// ============================================================================
// cte_checker
// Port level checks of the trace event decoder, bound to the top level.
// ============================================================================
module cte_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  event_kind,
    input  logic [15:0] address,
    input  logic [15:0] data_value,
    input  logic [3:0]  reg_id,
    input  logic [5:0]  cycle_count,
    input  logic [31:0] instr_index,
    input  logic        last_in_run
);

    // A stalled event beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(address) && $stable(data_value) && $stable(instr_index))
        else $error("event beat changed while stalled");

    // Once an error event is delivered, bytes are taken and dropped and no
    // event beat follows.
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (event_kind == 3'(cte_pkg::EV_ERROR))
            |=> in_ready && !out_valid)
        else $error("activity after reserved code");

    // Instruction events carry a cycle count in range.
    a_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == 3'(cte_pkg::EV_INSTR))
            |-> (cycle_count >= 6'd2) && (cycle_count <= 6'd37))
        else $error("cycle count out of range");

    // Register updates name one of the nine registers; errors end the run.
    a_reg_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_kind == 3'(cte_pkg::EV_REG)) && (reg_id > cte_pkg::REG_DP)
            || (event_kind == 3'(cte_pkg::EV_ERROR)) && !last_in_run) |-> 1'b0)
        else $error("bad register id or error event not last in run");

endmodule

bind cpu_trace_event_decoder cte_checker u_cte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .address    (address),
    .data_value (data_value),
    .reg_id     (reg_id),
    .cycle_count(cycle_count),
    .instr_index(instr_index),
    .last_in_run(last_in_run)
);

FILE: sim/tb_cpu_trace_event_decoder.sv
// ============================================================================
// tb_cpu_trace_event_decoder
// Self-checking testbench: packs trace codes into bytes, predicts the decoded
// event beats in its own decoder model and compares every output beat.
// ============================================================================
module tb_cpu_trace_event_decoder;

    localparam int WATCHDOG_CYCLES = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_BYTES    = 70;

    // Decoder state as the predictor tracks it.
    typedef struct packed {
        logic [39:0] pend;
        logic [5:0]  cnt;
        logic [15:0] last_rd;
        logic [31:0] instr_cnt;
        logic        halted;
    } dec_state_t;

    // One event beat with every output field.
    typedef struct packed {
        cte_pkg::kind_t kind;
        logic [15:0]    addr;
        logic [15:0]    data;
        logic [3:0]     rid;
        logic [1:0]     lid;
        logic           lvl;
        logic [5:0]     cycles;
        logic [31:0]    index;
        logic           last;
    } trace_event_t;

    // Code kinds the stimulus generator can pack into the stream.
    typedef enum int {
        SEL_WRITE, SEL_READ, SEL_SEQ_READ, SEL_INSTR_SHORT, SEL_INSTR_LONG,
        SEL_PC_SEQ, SEL_PC, SEL_A, SEL_B, SEL_X, SEL_Y, SEL_CC, SEL_U, SEL_S,
        SEL_DP, SEL_LINE, SEL_RSV_SHORT, SEL_RSV_LINE
    } code_sel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_kind;
    logic [15:0] address;
    logic [15:0] data_value;
    logic [3:0]  reg_id;
    logic [1:0]  line_id;
    logic        line_level;
    logic [5:0]  cycle_count;
    logic [31:0] instr_index;
    logic        last_in_run;

    dec_state_t   trace_state = '0;
    trace_event_t decoded_events [3];
    int           decoded_count;
    trace_event_t events_due [$];
    trace_event_t got_event;
    trace_event_t want_event;
    bit           tx_bits [$];
    bit           calm = 1'b0;
    bit           halt_allowed = 1'b0;
    int           bytes_taken = 0;
    int           events_seen = 0;
    int           error_count = 0;
    int           cycles_run = 0;

    cpu_trace_event_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .address     (address),
        .data_value  (data_value),
        .reg_id      (reg_id),
        .line_id     (line_id),
        .line_level  (line_level),
        .cycle_count (cycle_count),
        .instr_index (instr_index),
        .last_in_run (last_in_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run > WATCHDOG_CYCLES)
        begin
            $display("%0t: watchdog expired with %0d events outstanding",
                     $time, events_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // n bits starting pos bits after the oldest pending bit.
    function automatic logic [15:0] bits_at(input dec_state_t s, input int pos,
                                            input int n);
        logic [39:0] shifted;
        shifted = s.pend >> (int'(s.cnt) - pos - n);
        return 16'(shifted & ((40'd1 << n) - 40'd1));
    endfunction

    function automatic logic bit_at(input dec_state_t s, input int pos);
        return bits_at(s, pos, 1) != 16'd0;
    endfunction

    // Decodes the code at the head of the pending bits; returns its length,
    // or zero while it is still incomplete.
    function automatic int decode_next_code(inout dec_state_t s,
                                            output trace_event_t e);
        int c;
        int len;
        c = int'(s.cnt);
        e = '0;
        if (c < 3) return 0;
        if (bit_at(s, 0))
        begin
            if (bit_at(s, 1))
            begin
                // Explicit write or read, or sequential read.
                if (bit_at(s, 2))
                begin
                    if (c < 28) return 0;
                    e.addr = bits_at(s, 4, 16);
                    e.data = bits_at(s, 20, 8);
                    if (bit_at(s, 3))
                    begin
                        e.kind = cte_pkg::EV_WRITE;
                    end
                    else
                    begin
                        e.kind = cte_pkg::EV_READ;
                        s.last_rd = e.addr;
                    end
                    return 28;
                end
                if (c < 11) return 0;
                s.last_rd = s.last_rd + 16'd1;
                e.kind = cte_pkg::EV_READ;
                e.addr = s.last_rd;
                e.data = bits_at(s, 3, 8);
                return 11;
            end
            // Instruction start in its short or long form.
            e.kind = cte_pkg::EV_INSTR;
            if (bit_at(s, 2))
            begin
                if (c < 8) return 0;
                e.cycles = 6'(bits_at(s, 3, 5)) + cte_pkg::LONG_CYCLE_BASE;
                len = 8;
            end
            else
            begin
                if (c < 5) return 0;
                e.cycles = 6'(bits_at(s, 3, 2)) + cte_pkg::SHORT_CYCLE_BASE;
                len = 5;
            end
            e.index = s.instr_cnt;
            s.instr_cnt = s.instr_cnt + 32'd1;
            return len;
        end
        // Register updates, interrupt lines and the reserved codes.
        e.kind = cte_pkg::EV_REG;
        if (!bit_at(s, 1))
        begin
            e.rid = cte_pkg::REG_PC;
            if (!bit_at(s, 2))
            begin
                e.data = s.last_rd + 16'd1;
                return 3;
            end
            if (c < 19) return 0;
            e.data = bits_at(s, 3, 16);
            return 19;
        end
        if (!bit_at(s, 2))
        begin
            if (c < 12) return 0;
            e.rid = bit_at(s, 3) ? cte_pkg::REG_B : cte_pkg::REG_A;
            e.data = bits_at(s, 4, 8);
            return 12;
        end
        if (c < 5) return 0;
        case (bits_at(s, 3, 2))
            16'd0:
            begin
                if (c < 21) return 0;
                e.rid = cte_pkg::REG_X;
                e.data = bits_at(s, 5, 16);
                return 21;
            end
            16'd1:
            begin
                if (c < 21) return 0;
                e.rid = cte_pkg::REG_Y;
                e.data = bits_at(s, 5, 16);
                return 21;
            end
            16'd2:
            begin
                if (c < 13) return 0;
                e.rid = cte_pkg::REG_CC;
                e.data = bits_at(s, 5, 8);
                return 13;
            end
            default:
            begin
            end
        endcase
        if (c < 7) return 0;
        case (bits_at(s, 5, 2))
            16'd0:
            begin
                if (c < 23) return 0;
                e.rid = cte_pkg::REG_U;
                e.data = bits_at(s, 7, 16);
                return 23;
            end
            16'd1:
            begin
                if (c < 23) return 0;
                e.rid = cte_pkg::REG_S;
                e.data = bits_at(s, 7, 16);
                return 23;
            end
            16'd2:
            begin
                if (c < 15) return 0;
                e.rid = cte_pkg::REG_DP;
                e.data = bits_at(s, 7, 8);
                return 15;
            end
            default:
            begin
            end
        endcase
        if (c < 8) return 0;
        e.rid = cte_pkg::REG_PC;
        if (!bit_at(s, 7))
        begin
            e.kind = cte_pkg::EV_ERROR;
            s.halted = 1'b1;
            return 8;
        end
        if (c < 10) return 0;
        if (bits_at(s, 8, 2) == 16'd3)
        begin
            e.kind = cte_pkg::EV_ERROR;
            s.halted = 1'b1;
            return 10;
        end
        if (c < 11) return 0;
        e.kind = cte_pkg::EV_LINE;
        e.lid = 2'(bits_at(s, 8, 2));
        e.lvl = bit_at(s, 10);
        return 11;
    endfunction

    // Appends one byte and decodes up to three codes into decoded_events.
    task automatic decode_trace_byte(inout dec_state_t s, input logic [7:0] b);
        trace_event_t e;
        int used;
        decoded_count = 0;
        if (s.halted) return;
        s.pend = {s.pend[31:0], b};
        s.cnt = (s.cnt > 6'd32) ? 6'd40 : s.cnt + 6'd8;
        while (decoded_count < 3 && !s.halted)
        begin
            used = decode_next_code(s, e);
            if (used == 0) break;
            s.cnt = s.cnt - 6'(used);
            s.pend = s.pend & ((40'd1 << s.cnt) - 40'd1);
            decoded_events[decoded_count] = e;
            decoded_count++;
        end
        // Whatever follows a reserved code is dropped.
        if (s.halted)
        begin
            s.pend = '0;
            s.cnt = '0;
        end
        if (decoded_count > 0) decoded_events[decoded_count - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Sends one byte beat and records the events it is expected to cause.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int k;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        decode_trace_byte(trace_state, b);
        for (k = 0; k < decoded_count; k++) events_due.push_back(decoded_events[k]);
        bytes_taken++;
    endtask

    // Sends a byte, swapping it for a random one if it would halt the block
    // outside the halt test.
    task automatic send_checked(input logic [7:0] b);
        dec_state_t trial;
        logic [7:0] pick;
        pick = b;
        trial = trace_state;
        decode_trace_byte(trial, pick);
        while (trial.halted && !halt_allowed)
        begin
            pick = 8'($urandom);
            trial = trace_state;
            decode_trace_byte(trial, pick);
        end
        send_byte(pick);
    endtask

    task automatic put_bits(input logic [23:0] v, input int w);
        int i;
        for (i = w - 1; i >= 0; i--) tx_bits.push_back(v[i]);
    endtask

    task automatic flush_bytes();
        logic [7:0] b;
        int i;
        while (tx_bits.size() >= 8)
        begin
            for (i = 7; i >= 0; i--) b[i] = tx_bits.pop_front();
            send_checked(b);
        end
    endtask

    task automatic pad_to_byte();
        while (tx_bits.size() % 8 != 0) tx_bits.push_back(1'b0);
        flush_bytes();
    endtask

    // Feeds zero bytes until the decoder holds no pending bits, so that the
    // next generated code starts on a code boundary.
    task automatic realign();
        tx_bits.delete();
        while (trace_state.cnt != 6'd0) send_checked(8'h00);
    endtask

    // Packs one code, prefix then payload taken from the low bits of v.
    task automatic emit_code(input code_sel_t sel, input logic [23:0] v);
        case (sel)
            SEL_WRITE:       begin put_bits(24'b1111, 4); put_bits(v, 24); end
            SEL_READ:        begin put_bits(24'b1110, 4); put_bits(v, 24); end
            SEL_SEQ_READ:    begin put_bits(24'b110, 3); put_bits(v, 8); end
            SEL_INSTR_SHORT: begin put_bits(24'b100, 3); put_bits(v, 2); end
            SEL_INSTR_LONG:  begin put_bits(24'b101, 3); put_bits(v, 5); end
            SEL_PC_SEQ:      put_bits(24'b000, 3);
            SEL_PC:          begin put_bits(24'b001, 3); put_bits(v, 16); end
            SEL_A:           begin put_bits(24'b0100, 4); put_bits(v, 8); end
            SEL_B:           begin put_bits(24'b0101, 4); put_bits(v, 8); end
            SEL_X:           begin put_bits(24'b01100, 5); put_bits(v, 16); end
            SEL_Y:           begin put_bits(24'b01101, 5); put_bits(v, 16); end
            SEL_CC:          begin put_bits(24'b01110, 5); put_bits(v, 8); end
            SEL_U:           begin put_bits(24'b0111100, 7); put_bits(v, 16); end
            SEL_S:           begin put_bits(24'b0111101, 7); put_bits(v, 16); end
            SEL_DP:          begin put_bits(24'b0111110, 7); put_bits(v, 8); end
            SEL_LINE:        begin put_bits(24'b01111111, 8); put_bits(v, 3); end
            SEL_RSV_SHORT:   put_bits(24'b01111110, 8);
            default:         put_bits(24'b0111111111, 10);
        endcase
    endtask

    // Packs one well-formed code with random content.
    task automatic emit_random_code();
        code_sel_t sel;
        logic [23:0] v;
        sel = code_sel_t'($urandom_range(SEL_WRITE, SEL_LINE));
        v = 24'($urandom);
        // Addresses at 0xffff exercise the sequential wrap; 0x0000 is drawn as well.
        if ($urandom_range(0, 3) == 0) v[23:8] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        if (sel == SEL_LINE) v = {21'd0, 2'($urandom_range(0, 2)), 1'($urandom)};
        emit_code(sel, v);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A write, a read, a sequential read wrapping past 0xffff and a sequential pc.
    task automatic test_memory_codes();
        emit_code(SEL_WRITE, {16'hffff, 8'hff});
        emit_code(SEL_READ, {16'hffff, 8'h00});
        emit_code(SEL_SEQ_READ, 24'h00005a);
        emit_code(SEL_PC_SEQ, 24'd0);
        flush_bytes();
    endtask

    // Every register, most at extreme values; a run of sequential pc codes packs
    // three events into a single byte.
    task automatic test_register_codes();
        emit_code(SEL_PC, 24'h00ffff);
        emit_code(SEL_A, 24'h000000);
        emit_code(SEL_B, 24'h0000ff);
        emit_code(SEL_X, 24'h000000);
        emit_code(SEL_Y, 24'h00ffff);
        emit_code(SEL_CC, 24'h0000a5);
        emit_code(SEL_U, 24'h00ffff);
        emit_code(SEL_S, 24'h000000);
        emit_code(SEL_DP, 24'h0000ff);
        repeat (3) emit_code(SEL_PC_SEQ, 24'd0);
        flush_bytes();
    endtask

    // Shortest and longest cycle counts of both forms, and each interrupt line.
    task automatic test_instruction_and_line_codes();
        emit_code(SEL_INSTR_SHORT, 24'd0);
        emit_code(SEL_INSTR_SHORT, 24'd3);
        emit_code(SEL_INSTR_LONG, 24'd0);
        emit_code(SEL_INSTR_LONG, 24'd31);
        emit_code(SEL_LINE, {21'd0, 2'd0, 1'b0});
        emit_code(SEL_LINE, {21'd0, 2'd1, 1'b1});
        emit_code(SEL_LINE, {21'd0, 2'd2, 1'b1});
        flush_bytes();
    endtask

    // Mostly bursts of well-formed codes, with noise bytes and truncated
    // codes in between, each followed by realignment.
    task automatic test_random_trace();
        int target;
        int ncodes;
        int keep;
        int k;
        target = bytes_taken + RANDOM_BYTES;
        while (bytes_taken < target)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                ncodes = $urandom_range(1, 8);
                for (k = 0; k < ncodes; k++) emit_random_code();
                flush_bytes();
            end
            else
            begin
                pad_to_byte();
                if ($urandom_range(0, 1) == 1)
                begin
                    emit_random_code();
                    keep = $urandom_range(1, tx_bits.size() - 1);
                    while (tx_bits.size() > keep) void'(tx_bits.pop_back());
                    put_bits(24'($urandom), $urandom_range(0, 7));
                    pad_to_byte();
                end
                else
                begin
                    repeat ($urandom_range(1, 3)) send_checked(8'($urandom));
                end
                realign();
            end
        end
        calm = 1'b0;
    endtask

    // One of the two reserved codes, with a complete instruction code after
    // it that must be dropped, then bytes that are ignored.
    task automatic test_reserved_halt();
        pad_to_byte();
        realign();
        halt_allowed = 1'b1;
        emit_code(SEL_PC_SEQ, 24'd0);
        if ($urandom_range(0, 1) == 1) emit_code(SEL_RSV_SHORT, 24'd0);
        else emit_code(SEL_RSV_LINE, 24'd0);
        emit_code(SEL_INSTR_SHORT, 24'($urandom));
        pad_to_byte();
        repeat (3) send_checked(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Draws a stall before each event beat.
    initial
    begin : ready_driver
        int stall;
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    function automatic string event_text(input trace_event_t e);
        return $sformatf({"kind=%0d addr=%h data=%h reg=%0d line=%0d lvl=%0b",
                          " cyc=%0d idx=%0d last=%0b"},
                         e.kind, e.addr, e.data, e.rid, e.lid, e.lvl, e.cycles, e.index,
                         e.last);
    endfunction

    // Compares each event beat with the oldest expected event.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            got_event.kind   = cte_pkg::kind_t'(event_kind);
            got_event.addr   = address;
            got_event.data   = data_value;
            got_event.rid    = reg_id;
            got_event.lid    = line_id;
            got_event.lvl    = line_level;
            got_event.cycles = cycle_count;
            got_event.index  = instr_index;
            got_event.last   = last_in_run;
            events_seen++;
            if (events_due.size() == 0)
            begin
                error_count++;
                $display("%0t: event beat with none expected: %s", $time,
                         event_text(got_event));
            end
            else
            begin
                want_event = events_due.pop_front();
                if (got_event !== want_event)
                begin
                    error_count++;
                    $display("%0t: event mismatch, expected %s, actual %s", $time,
                             event_text(want_event), event_text(got_event));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_memory_codes();
        test_register_codes();
        test_instruction_and_line_codes();
        test_random_trace();
        test_reserved_halt();
        in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d trace bytes and checked %0d event beats.", bytes_taken, events_seen);
        $display("Covered every code type, noise with realignment and a reserved code halt.");
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
